/* design/alsf_pkg.sv */
// ----------------------------------------------------------------------------
// alsf_pkg: shared types and constants of the adaptive lag speed filter
// Field widths, filter depth, derived arithmetic widths and lane controls.
// ----------------------------------------------------------------------------
package alsf_pkg;

  // Number of filtered speeds kept per wheel (range 1 to 8).
  localparam int HISTORY_DEPTH = 3;

  localparam int COUNT_W    = 15;
  localparam int SPEED_W    = 16;
  localparam int COEF_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [COEF_W-1:0] LAG_GAIN_RESET = 16'd1638;
  localparam logic [COEF_W-1:0] GAIN_CAP_RESET = 16'd55705;
  localparam logic [SPEED_W-1:0] SAT_LIMIT     = 16'd32767;

  // Arithmetic widths; all but PROD1_W are derived from the history depth.
  localparam int SUM_W   = SPEED_W + $clog2(HISTORY_DEPTH);
  localparam int PROD1_W = SPEED_W + COEF_W + 2;
  localparam int PROD2_W = SUM_W + COEF_W + 1;
  localparam int NUM_W   = 35 + $clog2(HISTORY_DEPTH);
  localparam int MAG_W   = NUM_W - COEF_W;
  localparam int MAGC_W  = $clog2(HISTORY_DEPTH * 32768 + 1);

  // Magnitudes at or above this quotient-scaled limit saturate anyway.
  localparam logic [MAGC_W-1:0] MAG_CLAMP = MAGC_W'(HISTORY_DEPTH * 32768);
  // Reciprocal of the depth, scaled by 2^MAGC_W and rounded down.
  localparam logic [MAGC_W:0] RECIP = (MAGC_W + 1)'((64'd1 << MAGC_W) / HISTORY_DEPTH);

  // Work steps after the accepting edge.
  localparam int NUM_STEPS = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LAG_GAIN = 1'b0,
    REG_GAIN_CAP = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic load;
    logic calc_d;
    logic calc_gain;
    logic calc_prod;
    logic calc_num;
    logic calc_mag;
    logic calc_quot;
    logic commit;
  } lane_ctrl_t;

endpackage

/* design/alsf_if.sv */
// ----------------------------------------------------------------------------
// alsf_if: valid/ready channels of the adaptive lag speed filter
// One interface for encoder samples, one for filtered speeds.
// ----------------------------------------------------------------------------
interface alsf_in_if;
  logic                              valid;
  logic                              ready;
  logic [alsf_pkg::COUNT_W-1:0]      left_count;
  logic                              left_dir;
  logic [alsf_pkg::COUNT_W-1:0]      right_count;
  logic                              right_dir;

  modport source (output valid, left_count, left_dir, right_count, right_dir,
                  input ready);
  modport sink   (input valid, left_count, left_dir, right_count, right_dir,
                  output ready);
endinterface

interface alsf_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [alsf_pkg::SPEED_W-1:0] left_speed;
  logic signed [alsf_pkg::SPEED_W-1:0] right_speed;

  modport source (output valid, left_speed, right_speed, input ready);
  modport sink   (input valid, left_speed, right_speed, output ready);
endinterface

/* design/adaptive_lag_speed_filter_unit.sv */
// ----------------------------------------------------------------------------
// adaptive_lag_speed_filter_unit: two-wheel adaptive lag speed filter
// Turns encoder counts and direction pins into filtered signed speeds.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one sample transaction: a 15-bit count and a direction
//   pin per wheel. out_chan returns one transaction per sample with the
//   filtered left and right speeds, signed and saturated to +/-32767.
//   cfg_we/cfg_index/cfg_wdata write lag_gain (index 0) and gain_cap
//   (index 1); write them only while the filter is idle.
// Timing:
//   After acceptance the two wheel lanes step together through a
//   seven-step sequence (jump, gain, products, numerator, magnitude,
//   quotient, commit). The result then moves to the output register once
//   that register is free, and only after that is the next sample taken,
//   so the block works on one sample at a time.
// Reset and stalls:
//   Synchronous reset clears both histories, restores the default gains
//   and empties the output. If the receiver stalls, one finished result
//   waits in the output register while the next sample is still taken and
//   processed; the one after that waits until the output drains.
// ----------------------------------------------------------------------------
module adaptive_lag_speed_filter_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  alsf_in_if.sink                           in_chan,
  alsf_out_if.source                        out_chan,
  input  logic                              cfg_we,
  input  logic [alsf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [alsf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  logic [alsf_pkg::COEF_W-1:0]         lag_gain_r;
  logic [alsf_pkg::COEF_W-1:0]         gain_cap_r;
  logic [alsf_pkg::NUM_STEPS-1:0]      step_r;
  logic [alsf_pkg::NUM_STEPS-1:0]      step_nxt;
  logic                                in_accept;
  logic                                pending;
  logic                                busy;
  alsf_pkg::lane_ctrl_t                ctrl;
  logic signed [alsf_pkg::SPEED_W-1:0] left_raw;
  logic signed [alsf_pkg::SPEED_W-1:0] right_raw;
  logic signed [alsf_pkg::SPEED_W-1:0] left_y;
  logic signed [alsf_pkg::SPEED_W-1:0] right_y;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lag_gain_r <= alsf_pkg::LAG_GAIN_RESET;
      gain_cap_r <= alsf_pkg::GAIN_CAP_RESET;
    end else if (cfg_we) begin
      case (alsf_pkg::cfg_reg_t'(cfg_index))
        alsf_pkg::REG_LAG_GAIN: lag_gain_r <= cfg_wdata;
        alsf_pkg::REG_GAIN_CAP: gain_cap_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // One sample at a time: a new transaction is taken once the lanes are
  // done and their last result has moved into the output register.
  assign busy          = |step_r;
  assign in_chan.ready = !busy && !pending;
  assign in_accept     = in_chan.valid && in_chan.ready;

  // One-hot step sequencer; bit 0 runs in the cycle after acceptance.
  assign step_nxt = {step_r[alsf_pkg::NUM_STEPS-2:0], in_accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else begin
      step_r <= step_nxt;
    end
  end

  always_comb begin
    ctrl.load      = in_accept;
    ctrl.calc_d    = step_r[0];
    ctrl.calc_gain = step_r[1];
    ctrl.calc_prod = step_r[2];
    ctrl.calc_num  = step_r[3];
    ctrl.calc_mag  = step_r[4];
    ctrl.calc_quot = step_r[5];
    ctrl.commit    = step_r[6];
  end

  // Signed raw speeds. The left pin reads 0 as forward, the right pin as
  // reverse, since the two motors are mounted mirrored.
  always_comb begin
    left_raw  = alsf_pkg::SPEED_W'({1'b0, in_chan.left_count});
    right_raw = alsf_pkg::SPEED_W'({1'b0, in_chan.right_count});
    if (in_chan.left_dir) begin
      left_raw = -left_raw;
    end
    if (!in_chan.right_dir) begin
      right_raw = -right_raw;
    end
  end

  alsf_lane u_lane_left (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .raw      (left_raw),
    .lag_gain (lag_gain_r),
    .gain_cap (gain_cap_r),
    .speed    (left_y)
  );

  alsf_lane u_lane_right (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .raw      (right_raw),
    .lag_gain (lag_gain_r),
    .gain_cap (gain_cap_r),
    .speed    (right_y)
  );

  alsf_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .commit   (ctrl.commit),
    .left_y   (left_y),
    .right_y  (right_y),
    .out_chan (out_chan),
    .pending  (pending)
  );

  // At most one step of the sequence is active.
  a_step_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(step_r))
    else $error("filter sequencer has more than one active step");

  // An accepted transaction starts the sequence on the next cycle.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> step_r[0])
    else $error("accepted sample did not start the lanes");

  // Input is never offered while a sample is in flight or unsent.
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> (step_r == '0) && !pending)
    else $error("input ready while the lanes are busy");

  // A commit always leaves a result waiting for the output register.
  a_commit_pending: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.commit |=> pending)
    else $error("committed result was not held for output");

endmodule

/* design/alsf_lane.sv */
// ----------------------------------------------------------------------------
// alsf_lane: one wheel's adaptive lag filter
// Multi-step datapath with the wheel's history of filtered speeds.
// ----------------------------------------------------------------------------
module alsf_lane (
  input  logic                                clk,
  input  logic                                rst_n,
  input  alsf_pkg::lane_ctrl_t                ctrl,
  input  logic signed [alsf_pkg::SPEED_W-1:0] raw,
  input  logic [alsf_pkg::COEF_W-1:0]         lag_gain,
  input  logic [alsf_pkg::COEF_W-1:0]         gain_cap,
  output logic signed [alsf_pkg::SPEED_W-1:0] speed
);

  logic signed [alsf_pkg::SPEED_W-1:0] raw_r;
  logic signed [alsf_pkg::SPEED_W-1:0] hist_r [alsf_pkg::HISTORY_DEPTH];
  logic [alsf_pkg::SPEED_W-1:0]        diff_r;
  logic signed [alsf_pkg::SUM_W-1:0]   sum_r;
  logic [alsf_pkg::COEF_W-1:0]         a_r;
  logic signed [alsf_pkg::PROD1_W-1:0] m1_r;
  logic signed [alsf_pkg::PROD2_W-1:0] m2_r;
  logic signed [alsf_pkg::NUM_W-1:0]   num_r;
  logic                                neg_r;
  logic [alsf_pkg::MAGC_W-1:0]         mag_r;
  logic [alsf_pkg::SPEED_W-1:0]        q0_r;

  logic signed [alsf_pkg::SPEED_W:0]   diff_c;
  logic [alsf_pkg::SPEED_W:0]          diff_abs;
  logic signed [alsf_pkg::SUM_W-1:0]   sum_c;
  logic [2*alsf_pkg::COEF_W-1:0]       gain_prod;
  logic [alsf_pkg::COEF_W-1:0]         a_c;
  logic [alsf_pkg::COEF_W:0]           one_minus_a;
  logic signed [alsf_pkg::PROD1_W-1:0] m1_c;
  logic signed [alsf_pkg::PROD2_W-1:0] m2_c;
  logic signed [alsf_pkg::NUM_W-1:0]   num_c;
  logic [alsf_pkg::NUM_W-1:0]          num_abs;
  logic [alsf_pkg::MAG_W-1:0]          mag_full;
  logic [alsf_pkg::MAGC_W-1:0]         mag_c;
  logic [2*alsf_pkg::MAGC_W:0]         q_prod;
  logic [alsf_pkg::MAGC_W:0]           q0_times_d;
  logic [alsf_pkg::MAGC_W:0]           rem;
  logic [alsf_pkg::SPEED_W-1:0]        q_c;
  logic [alsf_pkg::SPEED_W-1:0]        q_sat;
  logic signed [alsf_pkg::SPEED_W-1:0] y_c;

  // Jump between the raw speed and the newest filtered speed, and the
  // history sum used for the mean.
  always_comb begin
    diff_c   = (alsf_pkg::SPEED_W + 1)'(raw_r) - (alsf_pkg::SPEED_W + 1)'(hist_r[0]);
    diff_abs = diff_c[alsf_pkg::SPEED_W] ? (alsf_pkg::SPEED_W + 1)'(-diff_c)
                                         : (alsf_pkg::SPEED_W + 1)'(diff_c);
    sum_c = '0;
    for (int i = 0; i < alsf_pkg::HISTORY_DEPTH; i++) begin
      sum_c = sum_c + alsf_pkg::SUM_W'(hist_r[i]);
    end
  end

  // Blend coefficient, capped.
  assign gain_prod = (2 * alsf_pkg::COEF_W)'(diff_r) * (2 * alsf_pkg::COEF_W)'(lag_gain);
  assign a_c = (gain_prod > (2 * alsf_pkg::COEF_W)'(gain_cap)) ? gain_cap
                                                               : gain_prod[alsf_pkg::COEF_W-1:0];

  // Both products of the blend.
  assign one_minus_a = (alsf_pkg::COEF_W + 1)'(1 << alsf_pkg::COEF_W)
                       - (alsf_pkg::COEF_W + 1)'(a_r);
  assign m1_c = alsf_pkg::PROD1_W'(raw_r)
                * alsf_pkg::PROD1_W'($signed({1'b0, one_minus_a}));
  assign m2_c = alsf_pkg::PROD2_W'(sum_r) * alsf_pkg::PROD2_W'($signed({1'b0, a_r}));

  assign num_c = alsf_pkg::NUM_W'(alsf_pkg::HISTORY_DEPTH) * alsf_pkg::NUM_W'(m1_r)
                 + alsf_pkg::NUM_W'(m2_r);

  // Magnitude divided by 2^16; anything past the clamp saturates later.
  assign num_abs  = num_r[alsf_pkg::NUM_W-1] ? alsf_pkg::NUM_W'(-num_r)
                                             : alsf_pkg::NUM_W'(num_r);
  assign mag_full = num_abs[alsf_pkg::NUM_W-1:alsf_pkg::COEF_W];
  assign mag_c    = (mag_full > alsf_pkg::MAG_W'(alsf_pkg::MAG_CLAMP))
                    ? alsf_pkg::MAG_CLAMP : mag_full[alsf_pkg::MAGC_W-1:0];

  // Division by the depth: reciprocal estimate, low by at most one.
  assign q_prod = (2 * alsf_pkg::MAGC_W + 1)'(mag_r)
                  * (2 * alsf_pkg::MAGC_W + 1)'(alsf_pkg::RECIP);

  always_comb begin
    q0_times_d = (alsf_pkg::MAGC_W + 1)'(q0_r)
                 * (alsf_pkg::MAGC_W + 1)'(alsf_pkg::HISTORY_DEPTH);
    rem        = (alsf_pkg::MAGC_W + 1)'(mag_r) - q0_times_d;
    q_c        = q0_r;
    if (rem >= (alsf_pkg::MAGC_W + 1)'(alsf_pkg::HISTORY_DEPTH)) begin
      q_c = q0_r + alsf_pkg::SPEED_W'(1);
    end
    q_sat = (q_c > alsf_pkg::SAT_LIMIT) ? alsf_pkg::SAT_LIMIT : q_c;
    y_c   = neg_r ? -$signed(q_sat) : $signed(q_sat);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < alsf_pkg::HISTORY_DEPTH; i++) begin
        hist_r[i] <= '0;
      end
    end else if (ctrl.commit) begin
      for (int i = alsf_pkg::HISTORY_DEPTH - 1; i > 0; i--) begin
        hist_r[i] <= hist_r[i-1];
      end
      hist_r[0] <= y_c;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      raw_r <= raw;
    end
    if (ctrl.calc_d) begin
      diff_r <= diff_abs[alsf_pkg::SPEED_W-1:0];
      sum_r  <= sum_c;
    end
    if (ctrl.calc_gain) begin
      a_r <= a_c;
    end
    if (ctrl.calc_prod) begin
      m1_r <= m1_c;
      m2_r <= m2_c;
    end
    if (ctrl.calc_num) begin
      num_r <= num_c;
    end
    if (ctrl.calc_mag) begin
      mag_r <= mag_c;
      neg_r <= num_r[alsf_pkg::NUM_W-1];
    end
    if (ctrl.calc_quot) begin
      q0_r <= q_prod[alsf_pkg::MAGC_W +: alsf_pkg::SPEED_W];
    end
  end

  assign speed = hist_r[0];

endmodule

/* design/alsf_merge.sv */
// ----------------------------------------------------------------------------
// alsf_merge: joins both lanes' speeds into one result transaction
// Holds a finished pair until the output register is free.
// ----------------------------------------------------------------------------
module alsf_merge (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                commit,
  input  logic signed [alsf_pkg::SPEED_W-1:0] left_y,
  input  logic signed [alsf_pkg::SPEED_W-1:0] right_y,
  alsf_out_if.source                          out_chan,
  output logic                                pending
);

  logic                                pending_r;
  logic                                pending_nxt;
  logic                                valid_r;
  logic                                valid_nxt;
  logic signed [alsf_pkg::SPEED_W-1:0] left_r;
  logic signed [alsf_pkg::SPEED_W-1:0] right_r;
  logic                                move;

  // The lanes hold their newest speed until the next commit, so a pending
  // pair can wait there while the output register is still occupied.
  assign move = pending_r && (!valid_r || out_chan.ready);

  always_comb begin
    pending_nxt = pending_r;
    if (commit) begin
      pending_nxt = 1'b1;
    end else if (move) begin
      pending_nxt = 1'b0;
    end
    valid_nxt = valid_r;
    if (move) begin
      valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
      valid_r   <= 1'b0;
    end else begin
      pending_r <= pending_nxt;
      valid_r   <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      left_r  <= left_y;
      right_r <= right_y;
    end
  end

  assign out_chan.valid       = valid_r;
  assign out_chan.left_speed  = left_r;
  assign out_chan.right_speed = right_r;
  assign pending              = pending_r;

endmodule
